// ===== hw/rtl/lr_pkg.sv =====
// Shared types and constants for the line rasterizer.
package lr_pkg;

  localparam int CoordBits  = 12;
  localparam int FrameBits  = 12;
  localparam int ColorBits  = 32;
  localparam int CfgIdxBits = 2;
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = $clog2(QueueDepth);
  localparam int QCntBits   = $clog2(QueueDepth + 1);

  localparam logic [FrameBits-1:0] FrameWidthRst  = FrameBits'(640);
  localparam logic [FrameBits-1:0] FrameHeightRst = FrameBits'(480);

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdTick = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    AxisX    = 2'd0,
    AxisY    = 2'd1,
    AxisDiag = 2'd2
  } axis_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFrameWidth  = CfgIdxBits'(0),
    CfgFrameHeight = CfgIdxBits'(1)
  } cfg_reg_e;

  // Decoded item handed from front to back.
  typedef struct packed {
    cmd_e                 cmd;
    axis_e                axis;
    logic [CoordBits-1:0] start_major;
    logic [CoordBits-1:0] start_minor;
    logic                 minor_neg;
    logic [CoordBits-1:0] mag;
    logic [CoordBits-1:0] span;
    logic [ColorBits-1:0] color;
  } line_cmd_t;

endpackage

// ===== hw/rtl/line_rasterizer_core.sv =====
// Line rasterizer top level: config registers, front, queue and back.
//
//  channel | dir | handshake                    | payload
//  in      | in  | in_valid_i / in_stall_o      | command, endpoints, line_color
//  pixel   | out | pixel_valid_o / pixel_stall_i | pixel_x/y, color, visible, last
//  cfg     | in  | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One item per cycle unless in_stall_o; a tick passes front reg, queue and out reg.
// The back end steps the minor axis with one remainder add/subtract per pixel.
// Reset clears the walk to idle and frame size to 640x480; cfg_ready_o is always high.
// A two-entry queue lets the input keep flowing while pixel_stall_i holds the output.
module line_rasterizer_core import lr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [CoordBits-1:0]  x_start_i,
  input  logic [CoordBits-1:0]  y_start_i,
  input  logic [CoordBits-1:0]  x_end_i,
  input  logic [CoordBits-1:0]  y_end_i,
  input  logic [ColorBits-1:0]  line_color_i,
  output logic                  pixel_valid_o,
  input  logic                  pixel_stall_i,
  output logic [CoordBits-1:0]  pixel_x_o,
  output logic [CoordBits-1:0]  pixel_y_o,
  output logic [ColorBits-1:0]  pixel_color_o,
  output logic                  visible_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [FrameBits-1:0]  cfg_data_i
);

  logic [FrameBits-1:0] frame_width_q, frame_height_q;
  logic                 q_full, q_push, q_pop, q_valid;
  line_cmd_t            q_in, q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgFrameWidth:  frame_width_q  <= cfg_data_i;
        CfgFrameHeight: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lr_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .x_start_i,
    .y_start_i,
    .x_end_i,
    .y_end_i,
    .line_color_i,
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_in)
  );

  lr_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  lr_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i      (q_valid),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .pixel_valid_o,
    .pixel_stall_i,
    .pixel_x_o,
    .pixel_y_o,
    .pixel_color_o,
    .visible_o,
    .last_o
  );

endmodule

// ===== hw/rtl/lr_front.sv =====
// Front end: accepts items, forms spans and classifies the major axis.
module lr_front import lr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [CoordBits-1:0] x_start_i,
  input  logic [CoordBits-1:0] y_start_i,
  input  logic [CoordBits-1:0] x_end_i,
  input  logic [CoordBits-1:0] y_end_i,
  input  logic [ColorBits-1:0] line_color_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output line_cmd_t            push_data_o
);

  logic                 valid_q;
  logic                 cmd_q;
  logic [CoordBits-1:0] x0_q, y0_q, x1_q, y1_q;
  logic [ColorBits-1:0] color_q;
  logic [CoordBits-1:0] adx_q, ady_q, adx_d, ady_d;
  logic                 dx_neg_q, dy_neg_q;
  logic [CoordBits:0]   dx, ndx, dy, ndy;
  logic                 advance;
  logic                 x_low, y_low;

  assign in_stall_o = valid_q & q_full_i;
  assign advance    = ~in_stall_o;
  assign push_o     = valid_q & ~q_full_i;

  always_comb begin
    dx    = {x_end_i[CoordBits-1], x_end_i} - {x_start_i[CoordBits-1], x_start_i};
    ndx   = {x_start_i[CoordBits-1], x_start_i} - {x_end_i[CoordBits-1], x_end_i};
    dy    = {y_end_i[CoordBits-1], y_end_i} - {y_start_i[CoordBits-1], y_start_i};
    ndy   = {y_start_i[CoordBits-1], y_start_i} - {y_end_i[CoordBits-1], y_end_i};
    adx_d = dx[CoordBits] ? ndx[CoordBits-1:0] : dx[CoordBits-1:0];
    ady_d = dy[CoordBits] ? ndy[CoordBits-1:0] : dy[CoordBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      cmd_q    <= command_i;
      x0_q     <= x_start_i;
      y0_q     <= y_start_i;
      x1_q     <= x_end_i;
      y1_q     <= y_end_i;
      color_q  <= line_color_i;
      adx_q    <= adx_d;
      ady_q    <= ady_d;
      dx_neg_q <= dx[CoordBits];
      dy_neg_q <= dy[CoordBits];
    end
  end

  // Walk starts at the low end of the major axis; minor sign follows.
  always_comb begin
    x_low = ~dx_neg_q;
    y_low = ~dy_neg_q;
    push_data_o.cmd   = cmd_e'(cmd_q);
    push_data_o.color = color_q;
    if (ady_q > adx_q) begin
      push_data_o.axis        = AxisY;
      push_data_o.span        = ady_q;
      push_data_o.mag         = adx_q;
      push_data_o.start_major = y_low ? y0_q : y1_q;
      push_data_o.start_minor = y_low ? x0_q : x1_q;
      push_data_o.minor_neg   = y_low ? dx_neg_q : ~dx_neg_q;
    end else begin
      push_data_o.axis        = (adx_q == ady_q) ? AxisDiag : AxisX;
      push_data_o.span        = adx_q;
      push_data_o.mag         = ady_q;
      push_data_o.start_major = x_low ? x0_q : x1_q;
      push_data_o.start_minor = x_low ? y0_q : y1_q;
      push_data_o.minor_neg   = x_low ? dy_neg_q : ~dy_neg_q;
    end
  end

endmodule

// ===== hw/rtl/lr_queue.sv =====
// Short item queue between front and back.
module lr_queue import lr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  line_cmd_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output line_cmd_t head_o
);

  line_cmd_t              mem_q [QueueDepth];
  logic [QPtrBits-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCntBits-1:0]    count_q;

  assign full_o  = (count_q == QCntBits'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("pop from empty queue");

endmodule

// ===== hw/rtl/lr_back.sv =====
// Back end: walks the line and drives the registered pixel output.
module lr_back import lr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  line_cmd_t            q_head_i,
  output logic                 q_pop_o,
  input  logic [FrameBits-1:0] frame_width_i,
  input  logic [FrameBits-1:0] frame_height_i,
  output logic                 pixel_valid_o,
  input  logic                 pixel_stall_i,
  output logic [CoordBits-1:0] pixel_x_o,
  output logic [CoordBits-1:0] pixel_y_o,
  output logic [ColorBits-1:0] pixel_color_o,
  output logic                 visible_o,
  output logic                 last_o
);

  logic                 busy_q;
  axis_e                axis_q;
  logic [CoordBits-1:0] major_q, minor_q;
  logic                 neg_q;
  logic [CoordBits-1:0] mag_q, span_q, final_q, step_q, rem_q;
  logic [ColorBits-1:0] color_q;

  logic                 out_valid_q;
  logic [CoordBits-1:0] out_x_q, out_y_q;
  logic [ColorBits-1:0] out_color_q;
  logic                 out_vis_q, out_last_q;

  logic                 out_free, is_load, emit;
  logic [CoordBits:0]   rem_sum;
  logic [CoordBits+1:0] rem_diff;
  logic                 minor_step;
  logic [CoordBits-1:0] px, py;
  logic                 is_last, vis;

  assign out_free = ~out_valid_q | ~pixel_stall_i;
  assign is_load  = (q_head_i.cmd == CmdLoad);
  assign emit     = q_valid_i & ~is_load & busy_q & out_free;
  assign q_pop_o  = q_valid_i & (is_load | ~busy_q | out_free);

  always_comb begin
    rem_sum    = {1'b0, rem_q} + {1'b0, mag_q};
    rem_diff   = {1'b0, rem_sum} - {2'b00, span_q};
    minor_step = ~rem_diff[CoordBits+1];
    px         = (axis_q == AxisY) ? minor_q : major_q;
    py         = (axis_q == AxisY) ? major_q : minor_q;
    is_last    = (step_q == final_q);
    vis        = ~px[CoordBits-1] & ~py[CoordBits-1] &
                 (FrameBits'(px) < frame_width_i) & (FrameBits'(py) < frame_height_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (q_pop_o && is_load) begin
      busy_q <= ~((q_head_i.axis == AxisDiag) && (q_head_i.span == '0));
    end else if (emit && is_last) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && is_load) begin
      axis_q  <= q_head_i.axis;
      major_q <= q_head_i.start_major;
      minor_q <= q_head_i.start_minor;
      neg_q   <= q_head_i.minor_neg;
      mag_q   <= q_head_i.mag;
      span_q  <= q_head_i.span;
      final_q <= (q_head_i.axis == AxisDiag) ? q_head_i.span - 1'b1 : q_head_i.span;
      step_q  <= '0;
      rem_q   <= '0;
      color_q <= q_head_i.color;
    end else if (emit) begin
      major_q <= major_q + 1'b1;
      step_q  <= step_q + 1'b1;
      if (minor_step) begin
        minor_q <= neg_q ? minor_q - 1'b1 : minor_q + 1'b1;
        rem_q   <= rem_diff[CoordBits-1:0];
      end else begin
        rem_q   <= rem_sum[CoordBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!pixel_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q     <= px;
      out_y_q     <= py;
      out_color_q <= color_q;
      out_vis_q   <= vis;
      out_last_q  <= is_last;
    end
  end

  assign pixel_valid_o = out_valid_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign pixel_color_o = out_color_q;
  assign visible_o     = out_vis_q;
  assign last_o        = out_last_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= final_q))
    else $error("walk ran past final step");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < span_q))
    else $error("remainder not below span");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> pixel_valid_o)
    else $error("emitted pixel not presented");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_valid_o && pixel_stall_i) |-> !emit)
    else $error("output overwritten while stalled");

endmodule
